>>> src/sacl_pkg.sv
// Shared types, constants and helpers for the LRU set-associative cache model.
package sacl_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int MAX_WAYS_CAP     = 32;
  localparam int WAY_FIELD_W      = $clog2(MAX_WAYS_CAP);

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 64;
  localparam int STAMP_W = 32;
  localparam int TOTAL_W = 32;

  localparam int OPCODE_W      = 2;
  localparam int SET_BITS_W    = 3;
  localparam int OFFSET_BITS_W = 6;
  localparam int WAYS_USED_W   = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 6;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NONE   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS_USED   = 2'd2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                   hit;
    logic [WAY_FIELD_W-1:0] hit_way;
    logic                   inv;
    logic [WAY_FIELD_W-1:0] inv_way;
    logic [WAY_FIELD_W-1:0] lru_way;
  } scan_res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

>>> src/sacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/sacl_split.sv
// Address splitter: shifts the byte address into set index and tag.
module sacl_split
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic [ADDR_W-1:0]        address,
  input  logic [SET_BITS_W-1:0]    set_bits,
  input  logic [OFFSET_BITS_W-1:0] offset_bits,
  output logic [SW-1:0]            set_idx,
  output logic [TAG_W-1:0]         tag
);

  logic [SET_BITS_W-1:0]  sb;
  logic [OFFSET_BITS_W:0] tag_sh;
  logic [ADDR_W-1:0]      blk;
  logic [ADDR_W-1:0]      set_mask;
  logic [ADDR_W-1:0]      set_full;

  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb = SET_BITS_W'(MAX_SET_BITS);
    end else begin
      sb = set_bits;
    end
    tag_sh   = {1'b0, offset_bits} + {{(OFFSET_BITS_W + 1 - SET_BITS_W){1'b0}}, sb};
    blk      = address >> offset_bits;
    set_mask = ~({ADDR_W{1'b1}} << sb);
    set_full = blk & set_mask;
    set_idx  = set_full[SW-1:0];
    if (tag_sh[OFFSET_BITS_W]) begin
      tag = '0;
    end else begin
      tag = address >> tag_sh[OFFSET_BITS_W-1:0];
    end
  end

endmodule

>>> src/sacl_scan.sv
// Way scan unit: tag compare and stamp compare, one way per cycle while step is high.
module sacl_scan
  import sacl_pkg::*;
#(
  parameter int MAX_WAYS = DEF_MAX_WAYS,
  localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             step,
  input  logic [WIW-1:0]   way,
  input  entry_t           entry,
  input  logic [TAG_W-1:0] tag,
  output scan_res_t        res
);

  logic               hit_r;
  logic               inv_r;
  logic [WIW-1:0]     hit_way_r;
  logic [WIW-1:0]     inv_way_r;
  logic [WIW-1:0]     lru_way_r;
  logic [STAMP_W-1:0] lru_stamp_r;
  logic               match;
  logic               older;

  assign match = entry.valid && (entry.tag == tag);
  assign older = (way == '0) || (entry.stamp < lru_stamp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      inv_r <= 1'b0;
    end else if (start) begin
      hit_r <= 1'b0;
      inv_r <= 1'b0;
    end else if (step) begin
      if (!hit_r && match) begin
        hit_r <= 1'b1;
      end
      if (!inv_r && !entry.valid) begin
        inv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (!hit_r && match) begin
        hit_way_r <= way;
      end
      if (!inv_r && !entry.valid) begin
        inv_way_r <= way;
      end
      if (older) begin
        lru_way_r   <= way;
        lru_stamp_r <= entry.stamp;
      end
    end
  end

  always_comb begin
    res         = '0;
    res.hit     = hit_r;
    res.inv     = inv_r;
    res.hit_way = WAY_FIELD_W'(hit_way_r);
    res.inv_way = WAY_FIELD_W'(inv_way_r);
    res.lru_way = WAY_FIELD_W'(lru_way_r);
  end

endmodule

>>> src/set_assoc_cache_lru_sim_unit.sv
// Top level: LRU set-associative cache model with access sequencer and totals.
//
//   channel  dir  handshake                     payload
//   in_      in   in_tvalid / in_tready         in_tdata: opcode, address
//   out_     out  out_tvalid / out_tready       out_tdata: hit..evict_total, out_tlast
//   cfg_     in   cfg_valid / cfg_ready         cfg_index, cfg_data
//
// One access runs through split, first read, a scan of each way in use
// through the scan unit on the single line RAM read port, then the write-back.
// A modify runs two accesses back to back. Opcode 3 is taken and dropped.
// After reset the line RAM is cleared, one line per cycle, all
// (1 << MAX_SET_BITS) * MAX_WAYS lines (512 by default); in_tready stays low.
// The write-back waits while a previous result is still held on the out side.
module set_assoc_cache_lru_sim_unit
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // opcode[1:0], address[65:2], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // hit, miss, evict, hit_total,
                                             // miss_total, evict_total, zero pad
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LINE_COUNT = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int LA  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int SW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SPLIT = 3'd2;
  localparam logic [2:0] ST_ISSUE = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [LA-1:0]            clr_r;
  logic [OPCODE_W-1:0]      op_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     second_r;
  logic [SW-1:0]            set_r;
  logic [TAG_W-1:0]         tag_r;
  logic [WIW-1:0]           ways_last_r, ways_last_nxt;
  logic [LA-1:0]            base_r;
  logic [WIW-1:0]           way_r;
  logic [STAMP_W-1:0]       clock_r;
  logic [TOTAL_W-1:0]       hits_r, misses_r, evicts_r;
  logic [STAMP_W-1:0]       clock_nxt;
  logic [TOTAL_W-1:0]       hits_nxt, misses_nxt, evicts_nxt;
  logic [SET_BITS_W-1:0]    set_bits_r;
  logic [OFFSET_BITS_W-1:0] offset_bits_r;
  logic [WAYS_USED_W-1:0]   ways_used_r;
  logic                     out_tvalid_r;
  logic [OUT_DATA_W-1:0]    out_tdata_r;
  logic                     out_tlast_r;

  logic [SW-1:0]    split_set;
  logic [TAG_W-1:0] split_tag;
  scan_res_t        res;
  logic             commit;
  logic             evict;
  logic             last;
  logic [WIW-1:0]   pick;
  logic             in_acc;
  logic             ram_we, ram_re;
  logic [LA-1:0]    ram_waddr, ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  sacl_split #(
    .MAX_SET_BITS(MAX_SET_BITS)
  ) u_split (
    .address    (addr_r),
    .set_bits   (set_bits_r),
    .offset_bits(offset_bits_r),
    .set_idx    (split_set),
    .tag        (split_tag)
  );

  sacl_scan #(
    .MAX_WAYS(MAX_WAYS)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .start(state_r == ST_ISSUE),
    .step (state_r == ST_SCAN),
    .way  (way_r),
    .entry(ram_rdata),
    .tag  (tag_r),
    .res  (res)
  );

  sacl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LINE_COUNT)
  ) u_lines (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (ways_used_r == '0) begin
      ways_last_nxt = '0;
    end else if (int'(ways_used_r) > MAX_WAYS) begin
      ways_last_nxt = WIW'(MAX_WAYS - 1);
    end else begin
      ways_last_nxt = WIW'(ways_used_r - WAYS_USED_W'(1));
    end
  end

  always_comb begin
    commit = (state_r == ST_WRITE) && (!out_tvalid_r || out_tready);
    evict  = !res.hit && !res.inv;
    last   = !((op_r == OP_MODIFY) && !second_r);
    if (res.hit) begin
      pick = res.hit_way[WIW-1:0];
    end else if (res.inv) begin
      pick = res.inv_way[WIW-1:0];
    end else begin
      pick = res.lru_way[WIW-1:0];
    end
    clock_nxt  = sat_inc(clock_r);
    hits_nxt   = res.hit ? sat_inc(hits_r) : hits_r;
    misses_nxt = res.hit ? misses_r : sat_inc(misses_r);
    evicts_nxt = evict ? sat_inc(evicts_r) : evicts_r;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (commit) begin
      ram_we          = 1'b1;
      ram_waddr       = base_r + LA'(pick);
      ram_wdata.valid = 1'b1;
      ram_wdata.tag   = tag_r;
      ram_wdata.stamp = clock_nxt;
    end
    ram_re    = (state_r == ST_ISSUE) || ((state_r == ST_SCAN) && (way_r != ways_last_r));
    ram_raddr = (state_r == ST_ISSUE) ? LA'(set_r) * LA'(MAX_WAYS)
                                      : base_r + LA'(way_r) + LA'(1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LA'(LINE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (in_tdata[OPCODE_W-1:0] != OP_NONE)) begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: state_nxt = ST_ISSUE;
      ST_ISSUE: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (way_r == ways_last_r) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (commit) begin
          state_nxt = last ? ST_IDLE : ST_SPLIT;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_r         <= '0;
      second_r      <= 1'b0;
      clock_r       <= '0;
      hits_r        <= '0;
      misses_r      <= '0;
      evicts_r      <= '0;
      set_bits_r    <= '0;
      offset_bits_r <= '0;
      ways_used_r   <= WAYS_USED_W'(1);
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + LA'(1);
      end
      if (in_acc) begin
        second_r <= 1'b0;
      end else if (commit) begin
        second_r <= 1'b1;
      end
      if (commit) begin
        clock_r  <= clock_nxt;
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        evicts_r <= evicts_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SET_BITS:    set_bits_r    <= cfg_data[SET_BITS_W-1:0];
          REG_OFFSET_BITS: offset_bits_r <= cfg_data[OFFSET_BITS_W-1:0];
          REG_WAYS_USED:   ways_used_r   <= cfg_data[WAYS_USED_W-1:0];
          default: ;
        endcase
      end
      if (commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_tdata[OPCODE_W-1:0];
      addr_r <= in_tdata[OPCODE_W +: ADDR_W];
    end
    if (state_r == ST_SPLIT) begin
      set_r       <= split_set;
      tag_r       <= split_tag;
      ways_last_r <= ways_last_nxt;
    end
    if (state_r == ST_ISSUE) begin
      base_r <= LA'(set_r) * LA'(MAX_WAYS);
      way_r  <= '0;
    end else if (state_r == ST_SCAN) begin
      way_r <= way_r + WIW'(1);
    end
    if (commit) begin
      out_tdata_r <= {(OUT_DATA_W - 3 - 3 * TOTAL_W)'(0), evicts_nxt, misses_nxt, hits_nxt,
                      evict, !res.hit, res.hit};
      out_tlast_r <= last;
    end
  end

  a_modify_second_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && second_r) |-> res.hit)
    else $error("second access of a modify missed");

  a_fill_way_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && !res.hit && res.inv) |-> (res.inv_way <= WAY_FIELD_W'(ways_last_r)))
    else $error("fill way beyond ways in use");

  a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (hits_r >= $past(hits_r)) && (misses_r >= $past(misses_r))
             && (evicts_r >= $past(evicts_r)))
    else $error("running total went down");

  a_one_total_per_access: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> ((hits_r != $past(hits_r)) || (misses_r != $past(misses_r))
                || ($past(hits_r) == '1) || ($past(misses_r) == '1)))
    else $error("access counted neither as hit nor miss");

endmodule

>>> sim/tb.sv
// Testbench for the LRU set-associative cache: queued accesses and register writes, random stalls.
`timescale 1ns / 1ps

module tb;
  import sacl_pkg::*;

  localparam int LINES         = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES   = 60;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_HOLD} plan_kind_e;

  typedef struct packed {
    plan_kind_e              kind;
    logic [OPCODE_W-1:0]     op;
    logic [ADDR_W-1:0]       addr;
    logic [CFG_INDEX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0]   value;
  } plan_entry_t;

  typedef struct packed {
    logic               hit;
    logic               miss;
    logic               evict;
    logic               last;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] evict_total;
  } lookup_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;   // opcode, address, zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;         // hit, miss, evict, hit_total,
                                             // miss_total, evict_total, zero pad
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  set_assoc_cache_lru_sim_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [SET_BITS_W-1:0]    split_set_bits    = '0;
  logic [OFFSET_BITS_W-1:0] split_offset_bits = '0;
  logic [WAYS_USED_W-1:0]   ways_cfg          = 4'd1;
  bit                       way_valid [LINES];
  bit [TAG_W-1:0]           way_tag   [LINES];
  bit [STAMP_W-1:0]         way_stamp [LINES];
  bit [STAMP_W-1:0]         tick;
  bit [TOTAL_W-1:0]         n_hit;
  bit [TOTAL_W-1:0]         n_miss;
  bit [TOTAL_W-1:0]         n_evict;

  lookup_t     lookups_due [$];
  plan_entry_t plan [$];
  logic [63:0] tag_pool [$];
  int          set_span;
  int          fails     = 0;
  int          quiet     = 0;
  int          send_gap  = 0;
  int          send_calm = 0;
  int          recv_gap  = 0;
  int          recv_calm = 0;
  bit          plan_done = 1'b0;

  function automatic void cache_lookup(input logic [ADDR_W-1:0] addr, input logic last_one);
    int      sb, off, ways, set_idx, base, pick, w;
    bit      found, placed;
    lookup_t res;
    logic [TAG_W-1:0] tag;
    sb   = (split_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(split_set_bits);
    off  = split_offset_bits;
    ways = (ways_cfg == 0) ? 1 : int'(ways_cfg);
    if (ways > DEF_MAX_WAYS) ways = DEF_MAX_WAYS;
    set_idx = int'((addr >> off) & ((64'd1 << sb) - 64'd1));
    tag     = (off + sb >= 64) ? '0 : (addr >> (off + sb));
    base    = set_idx * DEF_MAX_WAYS;
    if (tick != '1) tick++;
    found  = 1'b0;
    placed = 1'b0;
    res    = '0;
    for (w = 0; w < ways && !found; w++) begin
      if (way_valid[base + w] && way_tag[base + w] == tag) begin
        found = 1'b1;
        way_stamp[base + w] = tick;
      end
    end
    if (found) begin
      if (n_hit != '1) n_hit++;
    end else begin
      if (n_miss != '1) n_miss++;
      for (w = 0; w < ways && !placed; w++) begin
        if (!way_valid[base + w]) begin
          way_valid[base + w] = 1'b1;
          way_tag[base + w]   = tag;
          way_stamp[base + w] = tick;
          placed = 1'b1;
        end
      end
      if (!placed) begin
        pick = 0;
        for (w = 1; w < ways; w++)
          if (way_stamp[base + w] < way_stamp[base + pick]) pick = w;
        way_tag[base + pick]   = tag;
        way_stamp[base + pick] = tick;
        res.evict = 1'b1;
        if (n_evict != '1) n_evict++;
      end
    end
    res.hit         = found;
    res.miss        = !found;
    res.last        = last_one;
    res.hit_total   = n_hit;
    res.miss_total  = n_miss;
    res.evict_total = n_evict;
    lookups_due.push_back(res);
  endfunction

  function automatic void predict_item(input logic [OPCODE_W-1:0] op,
                                       input logic [ADDR_W-1:0] addr);
    case (op)
      OP_LOAD, OP_STORE: cache_lookup(addr, 1'b1);
      OP_MODIFY: begin
        cache_lookup(addr, 1'b0);
        cache_lookup(addr, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SET_BITS:    split_set_bits    = val[SET_BITS_W-1:0];
      REG_OFFSET_BITS: split_offset_bits = val[OFFSET_BITS_W-1:0];
      REG_WAYS_USED:   ways_cfg          = val[WAYS_USED_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(15, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic add_item(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr);
    plan_entry_t e;
    e      = '0;
    e.kind = ACT_ITEM;
    e.op   = op;
    e.addr = addr;
    plan.push_back(e);
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    plan_entry_t e;
    e         = '0;
    e.kind    = ACT_CFG;
    e.reg_idx = idx;
    e.value   = val;
    plan.push_back(e);
  endtask

  task automatic add_hold();
    plan_entry_t e;
    e      = '0;
    e.kind = ACT_HOLD;
    plan.push_back(e);
  endtask

  function automatic logic [ADDR_W-1:0] make_address(input int sb, input int off);
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    a = {$urandom, $urandom} & ((64'd1 << off) - 64'd1);
    a = a | (64'($urandom_range(0, set_span - 1)) << off);
    if (off + sb < 64) a = a | (tag_pool[$urandom_range(0, tag_pool.size() - 1)] << (off + sb));
    return a;
  endfunction

  task automatic add_phase(input int sb, input int off, input int ways, input int n,
                           input bit with_hold);
    int sb_eff, sets, done_items, r;
    logic [OPCODE_W-1:0] op;
    add_cfg(REG_SET_BITS, 6'(sb));
    add_cfg(REG_OFFSET_BITS, 6'(off));
    add_cfg(REG_WAYS_USED, 6'(ways));
    sb_eff   = (sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sb;
    sets     = 1 << sb_eff;
    set_span = $urandom_range(1, (sets < 3) ? sets : 3);
    tag_pool.delete();
    repeat ($urandom_range(2, 12))
      tag_pool.push_back(($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                     : 64'($urandom_range(0, 15)));
    done_items = 0;
    while (done_items < n) begin
      r  = $urandom_range(0, 99);
      op = (r < 35) ? OP_LOAD : (r < 65) ? OP_STORE : (r < 95) ? OP_MODIFY : OP_NONE;
      add_item(op, make_address(sb_eff, off));
      if (op != OP_NONE) begin
        done_items++;
        if (with_hold && done_items == n / 2) add_hold();
      end
    end
  endtask

  always @(posedge clk) begin : drive_items
    logic in_busy, cfg_busy, nv_in, nv_cfg;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data  <= '0;
    end else begin
      in_busy  = in_tvalid && !in_tready;
      cfg_busy = cfg_valid && !cfg_ready;
      if (in_tvalid && in_tready) predict_item(in_tdata[1:0], in_tdata[65:2]);
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (in_tvalid || lookups_due.size() != 0) quiet = 0;
      else quiet++;
      nv_in  = in_busy;
      nv_cfg = cfg_busy;
      if (!in_busy && !cfg_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (plan.size() == 0) begin
          plan_done = 1'b1;
        end else begin
          case (plan[0].kind)
            ACT_ITEM: begin
              nv_in = 1'b1;
              in_tdata <= {6'b0, plan[0].addr, plan[0].op};
              void'(plan.pop_front());
              send_gap = draw_gap(send_calm);
            end
            ACT_CFG: begin
              if (quiet >= SETTLE_CYCLES) begin
                nv_cfg = 1'b1;
                cfg_index <= plan[0].reg_idx;
                cfg_data  <= plan[0].value;
                void'(plan.pop_front());
              end
            end
            default: begin
              if (lookups_due.size() == 0) void'(plan.pop_front());
            end
          endcase
        end
      end
      in_tvalid <= nv_in;
      cfg_valid <= nv_cfg;
    end
  end

  always @(posedge clk) begin : watch_results
    lookup_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (lookups_due.size() == 0) begin
          $error("result with no access pending: out_tdata=%h", out_tdata);
          fails++;
        end else begin
          want = lookups_due.pop_front();
          check_field("hit", want.hit, out_tdata[0]);
          check_field("miss", want.miss, out_tdata[1]);
          check_field("evict", want.evict, out_tdata[2]);
          check_field("last", want.last, out_tlast);
          check_field("hit_total", want.hit_total, out_tdata[34:3]);
          check_field("miss_total", want.miss_total, out_tdata[66:35]);
          check_field("evict_total", want.evict_total, out_tdata[98:67]);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap = draw_gap(recv_calm);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    // reset split: one set, no offset, one way
    add_item(OP_LOAD, 64'd0);
    add_item(OP_LOAD, 64'd0);
    add_item(OP_STORE, '1);
    add_item(OP_MODIFY, '1);
    add_item(OP_NONE, '1);
    add_item(OP_LOAD, 64'd0);
    // set bits above the maximum, widest offset, zero ways
    add_cfg(REG_SET_BITS, 6'h3F);
    add_cfg(REG_OFFSET_BITS, 6'h3F);
    add_cfg(REG_WAYS_USED, 6'h00);
    add_item(OP_LOAD, 64'h8000_0000_0000_0000);
    add_item(OP_LOAD, 64'd0);
    add_item(OP_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
    // ways above the maximum, tag reduced to one bit
    add_cfg(REG_WAYS_USED, 6'h3F);
    add_cfg(REG_SET_BITS, 6'd3);
    add_cfg(REG_OFFSET_BITS, 6'd60);
    add_item(OP_STORE, 64'hF000_0000_0000_0000);
    add_item(OP_LOAD, 64'h5555_5555_5555_5555);
    add_item(OP_NONE, 64'd0);
    // two ways, walk the LRU order over kept lines
    add_cfg(REG_UNUSED, 6'h3F);
    add_cfg(REG_OFFSET_BITS, 6'd2);
    add_cfg(REG_SET_BITS, 6'd1);
    add_cfg(REG_WAYS_USED, 6'd2);
    add_item(OP_LOAD, 64'h08);
    add_item(OP_LOAD, 64'h10);
    add_item(OP_LOAD, 64'h08);
    add_item(OP_STORE, 64'h18);
    add_item(OP_MODIFY, 64'h10);
    add_item(OP_LOAD, 64'h08);

    add_phase(2, 4, 4, 80, 1'b0);
    add_phase(6, 6, 8, 80, 1'b0);
    add_phase(0, 0, 1, 80, 1'b0);
    add_phase(3, 5, 0, 80, 1'b1);
    add_phase(7, 63, 15, 80, 1'b0);
    add_phase(1, 58, 9, 80, 1'b0);
    add_phase(4, 0, 8, 80, 1'b0);
    add_phase(5, 12, 3, 80, 1'b0);
    add_phase($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 15), 80, 1'b0);
    add_phase($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 15), 80, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (!(plan_done && lookups_due.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
